// File: rtl/pointer_resolution_stepper_macros.svh
// Assertion helpers for the pointer resolution stepper.
// Each macro samples on clk_i and is switched off while rst_ni is low.
`ifndef POINTER_RESOLUTION_STEPPER_MACROS_SVH
`define POINTER_RESOLUTION_STEPPER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/prs_pkg.sv
`default_nettype none

package prs_pkg;

  localparam int unsigned CfgAddrW  = 5;
  localparam int unsigned SumW      = 34;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [31:0] StartResRst = 32'd1600;
  localparam logic [31:0] ResMinRst   = 32'd100;
  localparam logic [31:0] ResMaxRst   = 32'd12000;
  localparam logic [9:0]  StepSizeRst = 10'd100;
  localparam logic [7:0]  UpKeyRst    = 8'd0;
  localparam logic [7:0]  DownKeyRst  = 8'd1;
  localparam logic [7:0]  SettingLen  = 8'd4;

  typedef enum logic [2:0] {
    MODE_BUTTON     = 3'd0,
    MODE_SETTING    = 3'd1,
    MODE_MAIN_READY = 3'd2,
    MODE_POWER_DOWN = 3'd3,
    MODE_WAKE_UP    = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_SEND  = 2'd0,
    KIND_OFF   = 2'd1,
    KIND_READY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RUN_DISABLED = 2'd0,
    RUN_ACTIVE   = 2'd1,
    RUN_OFF      = 2'd2
  } run_state_e;

  typedef enum logic [2:0] {
    REG_RES_MIN   = 3'd0,
    REG_RES_MAX   = 3'd1,
    REG_STEP_SIZE = 3'd2,
    REG_START_RES = 3'd3,
    REG_UP_KEY    = 3'd4,
    REG_DOWN_KEY  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  key_id;
    logic        pressed;
    logic        for_resolution;
    logic [7:0]  payload_len;
    logic        own_echo;
    logic [31:0] new_value;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] res_value;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] res_min;
    logic [31:0] res_max;
    logic [9:0]  step_size;
    logic [7:0]  up_key;
    logic [7:0]  down_key;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/prs_regs.sv
`default_nettype none

module prs_regs
  import prs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  output cfg_t                     cfg_o
);

  cfg_t        cfg_q;
  logic [31:0] start_res_q;
  logic        wr_en;
  reg_idx_e    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[CfgAddrW-1:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.res_min   <= ResMinRst;
      cfg_q.res_max   <= ResMaxRst;
      cfg_q.step_size <= StepSizeRst;
      cfg_q.up_key    <= UpKeyRst;
      cfg_q.down_key  <= DownKeyRst;
      start_res_q     <= StartResRst;
    end else if (wr_en) begin
      case (idx)
        REG_RES_MIN:   cfg_q.res_min   <= pwdata;
        REG_RES_MAX:   cfg_q.res_max   <= pwdata;
        REG_STEP_SIZE: cfg_q.step_size <= pwdata[9:0];
        REG_START_RES: start_res_q     <= pwdata;
        REG_UP_KEY:    cfg_q.up_key    <= pwdata[7:0];
        REG_DOWN_KEY:  cfg_q.down_key  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RES_MIN:   prdata = cfg_q.res_min;
      REG_RES_MAX:   prdata = cfg_q.res_max;
      REG_STEP_SIZE: prdata = {22'd0, cfg_q.step_size};
      REG_START_RES: prdata = start_res_q;
      REG_UP_KEY:    prdata = {24'd0, cfg_q.up_key};
      REG_DOWN_KEY:  prdata = {24'd0, cfg_q.down_key};
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/prs_update.sv
`default_nettype none

module prs_update
  import prs_pkg::*;
#(
  parameter int unsigned RES_WIDTH  = 32,
  parameter int unsigned STEP_WIDTH = 8
) (
  input  wire logic        [RES_WIDTH-1:0]  res_now_i,
  input  wire logic signed [STEP_WIDTH-1:0] step_i,
  input  wire cfg_t                         cfg_i,
  input  wire logic                         resend_i,
  output logic             [RES_WIDTH-1:0]  nv_o,
  output logic                              send_o
);

  localparam int unsigned ProdW = STEP_WIDTH + 11;

  logic signed [ProdW-1:0] prod;
  logic signed [SumW-1:0]  sum;
  logic signed [SumW-1:0]  lo;
  logic signed [SumW-1:0]  hi;
  logic signed [SumW-1:0]  clamp;

  // The sum is wide enough that it never wraps.
  assign prod = step_i * $signed({1'b0, cfg_i.step_size});
  assign sum  = $signed({{(SumW-RES_WIDTH){1'b0}}, res_now_i})
              + $signed({{(SumW-ProdW){prod[ProdW-1]}}, prod});
  assign lo   = $signed({{(SumW-32){1'b0}}, cfg_i.res_min});
  assign hi   = $signed({{(SumW-32){1'b0}}, cfg_i.res_max});

  always_comb begin
    if (sum < lo) begin
      clamp = lo;
    end else if (sum > hi) begin
      clamp = hi;
    end else begin
      clamp = sum;
    end
    if (|clamp[SumW-1:RES_WIDTH]) begin
      nv_o = '1;
    end else begin
      nv_o = clamp[RES_WIDTH-1:0];
    end
  end

  assign send_o = (nv_o != res_now_i) || resend_i;

endmodule

`default_nettype wire

// File: rtl/prs_res_fifo.sv
`default_nettype none

module prs_res_fifo
  import prs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [1:0] push_n_i,
  input  wire out_t       data0_i,
  input  wire out_t       data1_i,
  output logic            room2_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_t            out_data_o
);

  out_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q;
  logic [FifoPtrW-1:0] rd_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room2_o     = (cnt_q <= FifoCntW'(FifoDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= data0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_q + FifoPtrW'(1)] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + FifoPtrW'(push_n_i);
      rd_q  <= rd_q + FifoPtrW'(pop);
      cnt_q <= cnt_q + FifoCntW'(push_n_i) - FifoCntW'(pop);
    end
  end

endmodule

`default_nettype wire

// File: rtl/pointer_resolution_stepper.sv
// Pointer resolution stepper.
// Input beats on in_valid_i/in_ready_o carry one event (button, setting
// message, main ready, power down or wake up). Result beats on
// out_valid_o/out_ready_i carry a setting to store, an off report or a ready
// report; the last flag marks the final result of an event. An event gives at
// most two results, a wake-up that also sends a setting being the only such
// case. Registers must be written over the APB port only while the block is
// idle; the block itself does not enforce this. An accepted event is held in
// an input register and is then processed by one multiply, add and clamp pass
// into a four-entry result queue, from which its first result beat is offered.
// One event is accepted every cycle while the queue has room for two
// results; while out_ready_i is high the queue drains one beat per cycle, so
// the sustained rate is set by the number of result beats the receiver takes.
// Reset empties the queue, puts the block in the disabled state and loads the
// stored setting with the reset value of start_res. When the receiver stalls,
// the queue fills and in_ready_o drops until two entries are free again.
`default_nettype none
`include "pointer_resolution_stepper_macros.svh"

module pointer_resolution_stepper
  import prs_pkg::*;
#(
  parameter int unsigned RES_WIDTH  = 32,
  parameter int unsigned STEP_WIDTH = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_t                 in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_t                     out_data_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  localparam logic signed [STEP_WIDTH-1:0] StepMax = {1'b0, {(STEP_WIDTH-1){1'b1}}};
  localparam logic signed [STEP_WIDTH-1:0] StepLow = -StepMax;

  cfg_t cfg;

  in_t  it_q;
  logic it_vld_q;
  logic process;
  logic room2;

  run_state_e                     rs_q, rs_d;
  logic        [RES_WIDTH-1:0]    res_q, res_d;
  logic signed [STEP_WIDTH-1:0]   sc_q, sc_d;
  logic                           aw_q, aw_d;
  logic                           rsd_q, rsd_d;

  logic signed [STEP_WIDTH-1:0]   upd_step;
  logic                           run_upd;
  logic        [RES_WIDTH-1:0]    upd_nv;
  logic                           upd_send;
  logic                           push_send;
  logic        [1:0]              push_n;
  logic        [1:0]              res_n;
  out_t                           r0;
  out_t                           r1;

  prs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  prs_update #(
    .RES_WIDTH  (RES_WIDTH),
    .STEP_WIDTH (STEP_WIDTH)
  ) u_update (
    .res_now_i (res_q),
    .step_i    (upd_step),
    .cfg_i     (cfg),
    .resend_i  (rsd_q),
    .nv_o      (upd_nv),
    .send_o    (upd_send)
  );

  prs_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .data0_i     (r0),
    .data1_i     (r1),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  assign process    = it_vld_q && room2;
  assign in_ready_o = !it_vld_q || process;
  assign push_n     = process ? res_n : 2'd0;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      it_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      it_vld_q <= in_valid_i;
    end
  end

  always_comb begin
    rs_d      = rs_q;
    res_d     = res_q;
    sc_d      = sc_q;
    aw_d      = aw_q;
    rsd_d     = rsd_q;
    upd_step  = sc_q;
    run_upd   = 1'b0;
    push_send = 1'b0;
    res_n     = 2'd0;
    r0        = '0;
    r1        = '0;

    case (mode_e'(it_q.mode))
      MODE_BUTTON: begin
        if (it_q.pressed) begin
          if (it_q.key_id == cfg.up_key) begin
            upd_step = (sc_q < StepMax) ? sc_q + STEP_WIDTH'(1) : sc_q;
            sc_d     = upd_step;
            run_upd  = 1'b1;
          end else if (it_q.key_id == cfg.down_key) begin
            upd_step = (sc_q > StepLow) ? sc_q - STEP_WIDTH'(1) : sc_q;
            sc_d     = upd_step;
            run_upd  = 1'b1;
          end
        end
      end
      MODE_SETTING: begin
        if (it_q.for_resolution && (it_q.payload_len == SettingLen)) begin
          if (it_q.own_echo && aw_q) begin
            aw_d    = 1'b0;
            run_upd = 1'b1;
          end else begin
            res_d = it_q.new_value[RES_WIDTH-1:0];
            sc_d  = '0;
            if (aw_q) begin
              rsd_d = 1'b1;
            end
          end
        end
      end
      MODE_MAIN_READY: begin
        if (rs_q == RUN_DISABLED) begin
          rs_d = RUN_ACTIVE;
        end
      end
      MODE_POWER_DOWN: begin
        if (rs_q != RUN_OFF) begin
          rs_d    = RUN_OFF;
          res_n   = 2'd1;
          r0.kind = KIND_OFF;
        end
      end
      MODE_WAKE_UP: begin
        if (rs_q != RUN_ACTIVE) begin
          rs_d    = RUN_ACTIVE;
          res_n   = 2'd1;
          r0.kind = KIND_READY;
          run_upd = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // The update is skipped while off or while our own message is in flight.
    if (run_upd && (rs_d != RUN_OFF) && !aw_d) begin
      sc_d  = '0;
      rsd_d = 1'b0;
      res_d = upd_nv;
      if (upd_send) begin
        aw_d      = 1'b1;
        push_send = 1'b1;
        if (res_n == 2'd0) begin
          r0.kind      = KIND_SEND;
          r0.res_value = 32'(upd_nv);
        end else begin
          r1.kind      = KIND_SEND;
          r1.res_value = 32'(upd_nv);
        end
        res_n = res_n + 2'd1;
      end
    end

    if (res_n == 2'd1) begin
      r0.last = 1'b1;
    end else if (res_n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q  <= RUN_DISABLED;
      res_q <= StartResRst[RES_WIDTH-1:0];
      sc_q  <= '0;
      aw_q  <= 1'b0;
      rsd_q <= 1'b0;
    end else if (process) begin
      rs_q  <= rs_d;
      res_q <= res_d;
      sc_q  <= sc_d;
      aw_q  <= aw_d;
      rsd_q <= rsd_d;
    end
  end

  `PRS_ASSERT_NEXT(a_send_sets_await, process && push_send, aw_q, "send did not arm echo wait")
  `PRS_ASSERT_NOW(a_off_no_send,
                  process && (rs_q == RUN_OFF) && (it_q.mode != MODE_WAKE_UP), !push_send,
                  "setting sent while off")
  `PRS_ASSERT_NOW(a_step_range, 1'b1, (sc_q >= StepLow), "step count out of range")

endmodule

`default_nettype wire
